[rtl/core/awpw_pkg.sv]
// Shared types, constants and defaults for the address window pixel writer.
package awpw_pkg;

    localparam int DEF_SCREEN_COLS = 128;
    localparam int DEF_SCREEN_ROWS = 128;
    localparam int DEF_ROW_PITCH   = 128;
    localparam int DEF_PAGE_ROWS   = 128;

    localparam int COORD_W     = 7;   // on-screen row/col, screen is at most 128 wide/high
    localparam int ADDR_W      = 15;
    localparam int PIX_W       = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_WINDOW = 2'd0,
        FUNC_PIXEL  = 2'd1,
        FUNC_FLIP   = 2'd2
    } t_func;

    // One command from the cursor front end to the write back end.
    typedef struct packed {
        logic               we;
        logic               page;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pixel;
    } t_cmd;

endpackage

[rtl/core/awpw_front.sv]
// Front end: window and cursor state, classifies each beat into a write command.
module awpw_front import awpw_pkg::*; #(
    parameter int SCREEN_COLS = DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_func,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic signed [15:0] i_w,
    input  logic signed [15:0] i_h,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic               i_swap,
    output t_cmd               o_cmd
);

    localparam logic signed [15:0] COLS_LIM = 16'(SCREEN_COLS);
    localparam logic signed [15:0] ROWS_LIM = 16'(SCREEN_ROWS);
    localparam logic signed [15:0] ROW_MAX  = 16'sh7FFF;

    logic signed [15:0] r_left, n_left;
    logic signed [15:0] r_right, n_right;
    logic signed [15:0] r_col, n_col;
    logic signed [15:0] r_row, n_row;
    logic               r_page, n_page;

    logic signed [16:0] right_sum;
    logic               on_screen;
    logic [PIX_W-1:0]   pix_ordered;

    assign right_sum   = {i_x[15], i_x} + {i_w[15], i_w} - 17'sd1;
    assign on_screen   = !r_col[15] && (r_col < COLS_LIM) && !r_row[15] && (r_row < ROWS_LIM);
    assign pix_ordered = i_swap ? i_pixel : {i_pixel[7:0], i_pixel[15:8]};

    always_comb begin
        n_left  = r_left;
        n_right = r_right;
        n_col   = r_col;
        n_row   = r_row;
        n_page  = r_page;
        o_cmd   = '0;
        case (i_func)
            FUNC_WINDOW: begin
                if (i_w > 16'sd0 && i_h > 16'sd0) begin
                    n_left  = i_x;
                    // right edge saturates at the top of the signed range
                    n_right = (!right_sum[16] && right_sum[15]) ? ROW_MAX : right_sum[15:0];
                    n_col   = i_x;
                    n_row   = i_y;
                end
            end
            FUNC_PIXEL: begin
                if (on_screen) begin
                    o_cmd.we    = 1'b1;
                    o_cmd.page  = r_page;
                    o_cmd.row   = r_row[COORD_W-1:0];
                    o_cmd.col   = r_col[COORD_W-1:0];
                    o_cmd.pixel = pix_ordered;
                end
                if (r_col >= r_right) begin
                    n_col = r_left;
                    if (r_row != ROW_MAX) begin
                        n_row = r_row + 16'sd1;
                    end
                end else begin
                    n_col = r_col + 16'sd1;
                end
            end
            FUNC_FLIP: begin
                n_page = !r_page;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= -16'sd1;
            r_col   <= '0;
            r_row   <= '0;
            r_page  <= 1'b0;
        end else if (i_accept) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_col   <= n_col;
            r_row   <= n_row;
            r_page  <= n_page;
        end
    end

endmodule

[rtl/core/awpw_queue.sv]
// Short command queue that decouples the front end from the back end.
module awpw_queue import awpw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

[rtl/core/awpw_back.sv]
// Back end: forms the frame memory address and BGR555 color, holds the result beat.
module awpw_back import awpw_pkg::*; #(
    parameter int ROW_PITCH = DEF_ROW_PITCH,
    parameter int PAGE_ROWS = DEF_PAGE_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_cmd              i_cmd,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_empty,
    output logic              o_write_enable,
    output logic [ADDR_W-1:0] o_address,
    output logic [PIX_W-1:0]  o_color_out
);

    localparam int                PAGE_SIZE = PAGE_ROWS * ROW_PITCH;
    localparam logic [ADDR_W-1:0] PAGE_OFS  = ADDR_W'(PAGE_SIZE % (2 ** ADDR_W));
    localparam logic [ADDR_W-1:0] PITCH     = ADDR_W'(ROW_PITCH);

    logic              r_valid;
    logic              r_we;
    logic [ADDR_W-1:0] r_addr;
    logic [PIX_W-1:0]  r_color;

    logic [ADDR_W-1:0] row_ofs;
    logic [ADDR_W-1:0] n_addr;
    logic [PIX_W-1:0]  n_color;
    logic              take;

    assign row_ofs = ADDR_W'(i_cmd.row) * PITCH;
    assign n_addr  = row_ofs + ADDR_W'(i_cmd.col) + (i_cmd.page ? PAGE_OFS : '0);
    assign n_color = {1'b1, i_cmd.pixel[4:0], i_cmd.pixel[10:6], i_cmd.pixel[15:11]};

    assign o_ready = !r_valid || i_pop;
    assign take    = i_valid && o_ready;

    assign o_empty        = !r_valid;
    assign o_write_enable = r_we;
    assign o_address      = r_addr;
    assign o_color_out    = r_color;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_we    <= i_cmd.we;
            r_addr  <= i_cmd.we ? n_addr : '0;
            r_color <= i_cmd.we ? n_color : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

endmodule

[rtl/core/address_window_pixel_writer.sv]
// Top level of the address window pixel writer: front end, command queue, back end.
//
// Every accepted input beat yields exactly one result beat, in order. A set-window beat
// (func 0) loads the window left/right edges and parks the cursor at x,y; it is dropped
// when w or h is not positive, and the right edge x+w-1 saturates at 32767. A pixel beat
// (func 1) byte-swaps the RGB565 value when swap is 0, converts it to BGR555 with bit 15
// set and reports a write at page*PAGE_ROWS*ROW_PITCH + row*ROW_PITCH + col (mod 2^15)
// when the cursor is on screen; the cursor then steps right, wrapping to the left edge
// of the next row once it reaches the right edge, and the row saturates at 32767. A flip
// beat (func 2) toggles the draw page; func 3 does nothing. Any beat without a write
// returns write_enable, address and color_out all zero. Throughput is one beat per
// clock while neither side stalls: the cursor update is a combinational compare and
// increment in the front end, and the back end does one constant multiply and add per
// beat. With nothing queued, a result is written into the two-entry queue first and
// then loaded into the output register, where it shows on the output ports and can be
// popped. Both sides may stall freely; full rises only once the queue holds two
// commands the back end could not pass on.
module address_window_pixel_writer import awpw_pkg::*; #(
    parameter int SCREEN_COLS = DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = DEF_SCREEN_ROWS,
    parameter int ROW_PITCH   = DEF_ROW_PITCH,
    parameter int PAGE_ROWS   = DEF_PAGE_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input beat side
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_func,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic signed [15:0] i_w,
    input  logic signed [15:0] i_h,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic               i_swap,
    // result beat side
    output logic               empty,
    input  logic               pop,
    output logic               o_write_enable,
    output logic [ADDR_W-1:0]  o_address,
    output logic [PIX_W-1:0]   o_color_out
);

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic accept;
    logic q_valid;
    logic back_ready;

    // a beat is taken whenever the queue has room
    assign accept = push && !full;

    awpw_front #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_func  (i_func),
        .i_x     (i_x),
        .i_y     (i_y),
        .i_w     (i_w),
        .i_h     (i_h),
        .i_pixel (i_pixel),
        .i_swap  (i_swap),
        .o_cmd   (front_cmd)
    );

    awpw_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (front_cmd),
        .o_full (full),
        .o_valid(q_valid),
        .i_pop  (back_ready),
        .o_cmd  (q_cmd)
    );

    // back end pulls from the queue whenever its output register frees up
    awpw_back #(
        .ROW_PITCH(ROW_PITCH),
        .PAGE_ROWS(PAGE_ROWS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_cmd         (q_cmd),
        .o_ready       (back_ready),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_write_enable(o_write_enable),
        .o_address     (o_address),
        .o_color_out   (o_color_out)
    );

`ifndef SYNTHESIS
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_write_enable) |-> (o_address == '0 && o_color_out == '0))
        else $error("result without write carries nonzero payload");

    a_color_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_write_enable) |-> o_color_out[15])
        else $error("written color lacks bit 15");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && !back_ready) |=> full)
        else $error("queue lost an entry while the back end stalled");

    a_back_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && back_ready) |=> !empty)
        else $error("command handed to back end produced no result");
`endif

endmodule
